// ===== rtl/cpu8_alu_with_flags_assert.svh =====
// Assertion macros used by the ALU top level.
`ifndef CPU8_ALU_WITH_FLAGS_ASSERT_SVH
`define CPU8_ALU_WITH_FLAGS_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CPU8_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CPU8_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cpu8a_pkg.sv =====
// Package with the beat types, operation codes and flag positions of the ALU.
package cpu8a_pkg;

  // Operation codes, numbered densely.
  typedef enum logic [5:0] {
    OP_ADD   = 6'd0,
    OP_ADC   = 6'd1,
    OP_SUB   = 6'd2,
    OP_SBC   = 6'd3,
    OP_CP    = 6'd4,
    OP_AND   = 6'd5,
    OP_OR    = 6'd6,
    OP_XOR   = 6'd7,
    OP_INC   = 6'd8,
    OP_DEC   = 6'd9,
    OP_CPL   = 6'd10,
    OP_RLC   = 6'd11,
    OP_RRC   = 6'd12,
    OP_RL    = 6'd13,
    OP_RR    = 6'd14,
    OP_SLA   = 6'd15,
    OP_SRA   = 6'd16,
    OP_SRL   = 6'd17,
    OP_SWAP  = 6'd18,
    OP_RLCA  = 6'd19,
    OP_RRCA  = 6'd20,
    OP_RLA   = 6'd21,
    OP_RRA   = 6'd22,
    OP_BIT   = 6'd23,
    OP_RES   = 6'd24,
    OP_SET   = 6'd25,
    OP_DAA   = 6'd26,
    OP_CCF   = 6'd27,
    OP_SCF   = 6'd28,
    OP_ADDHL = 6'd29,
    OP_ADDSP = 6'd30,
    OP_INC16 = 6'd31,
    OP_DEC16 = 6'd32
  } op_t;

  // Flag bit positions in the 4-bit flag word.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // One input beat.
  typedef struct packed {
    logic [5:0]  func;
    logic [15:0] operand_x;
    logic [15:0] operand_y;
    logic [3:0]  flags_in;
    logic [2:0]  bit_index;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        writes_result;
  } out_t;

endpackage

// ===== rtl/cpu8a_alu.sv =====
// Combinational datapath of the ALU: result, flags and write strobe for one beat.
module cpu8a_alu (
  input  cpu8a_pkg::in_t  item,
  output cpu8a_pkg::out_t res
);
  import cpu8a_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic [3:0]  f;
  logic        cf;
  logic        ci;
  logic [8:0]  add9;
  logic [4:0]  add_nib;
  logic [8:0]  sub9;
  logic [4:0]  sub_nib;
  logic [16:0] hl17;
  logic [12:0] hl13;
  logic [15:0] e16;
  logic [8:0]  sp_low9;
  logic [4:0]  sp_nib;
  logic [7:0]  bit_mask;

  assign a  = item.operand_x[7:0];
  assign b  = item.operand_y[7:0];
  assign f  = item.flags_in;
  assign cf = f[FLAG_C];

  // Carry enters only for ADC and SBC.
  assign ci = (item.func == OP_ADC || item.func == OP_SBC) ? cf : 1'b0;

  // Shared adders and subtractors for the 8-bit arithmetic group.
  assign add9    = {1'b0, a} + {1'b0, b} + {8'h00, ci};
  assign add_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, ci};
  assign sub9    = {1'b0, a} - {1'b0, b} - {8'h00, ci};
  assign sub_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, ci};

  // 16-bit add for ADD HL,r16 with carry out of bit 11 and bit 15.
  assign hl17 = {1'b0, item.operand_x} + {1'b0, item.operand_y};
  assign hl13 = {1'b0, item.operand_x[11:0]} + {1'b0, item.operand_y[11:0]};

  // SP plus signed offset; flags come from the unsigned low-byte add.
  assign e16     = {{8{b[7]}}, b};
  assign sp_low9 = {1'b0, item.operand_x[7:0]} + {1'b0, b};
  assign sp_nib  = {1'b0, item.operand_x[3:0]} + {1'b0, b[3:0]};

  assign bit_mask = 8'h01 << item.bit_index;

  // Operation select.
  always_comb begin
    logic [7:0]  r8;
    logic [7:0]  adj;
    logic        cy;
    logic        wide;
    logic [15:0] r16;
    logic [3:0]  nf;
    logic        wr;

    r8   = 8'h00;
    adj  = 8'h00;
    cy   = cf;
    wide = 1'b0;
    r16  = 16'h0000;
    nf   = f;
    wr   = 1'b1;

    case (item.func)
      OP_ADD, OP_ADC: begin
        r8 = add9[7:0];
        nf = {r8 == 8'h00, 1'b0, add_nib[4], add9[8]};
      end
      OP_SUB, OP_SBC: begin
        r8 = sub9[7:0];
        nf = {r8 == 8'h00, 1'b1, sub_nib[4], sub9[8]};
      end
      OP_CP: begin
        wr = 1'b0;
        nf = {sub9[7:0] == 8'h00, 1'b1, sub_nib[4], sub9[8]};
      end
      OP_AND: begin
        r8 = a & b;
        nf = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_OR: begin
        r8 = a | b;
        nf = {r8 == 8'h00, 3'b000};
      end
      OP_XOR: begin
        r8 = a ^ b;
        nf = {r8 == 8'h00, 3'b000};
      end
      OP_INC: begin
        r8 = a + 8'h01;
        nf = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cf};
      end
      OP_DEC: begin
        r8 = a - 8'h01;
        nf = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cf};
      end
      OP_CPL: begin
        r8 = ~a;
        nf = f;
        nf[FLAG_N] = 1'b1;
        nf[FLAG_H] = 1'b1;
      end
      OP_RLC: begin
        r8 = {a[6:0], a[7]};
        nf = {r8 == 8'h00, 2'b00, a[7]};
      end
      OP_RRC: begin
        r8 = {a[0], a[7:1]};
        nf = {r8 == 8'h00, 2'b00, a[0]};
      end
      OP_RL: begin
        r8 = {a[6:0], cf};
        nf = {r8 == 8'h00, 2'b00, a[7]};
      end
      OP_RR: begin
        r8 = {cf, a[7:1]};
        nf = {r8 == 8'h00, 2'b00, a[0]};
      end
      OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        nf = {r8 == 8'h00, 2'b00, a[7]};
      end
      OP_SRA: begin
        r8 = {a[7], a[7:1]};
        nf = {r8 == 8'h00, 2'b00, a[0]};
      end
      OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        nf = {r8 == 8'h00, 2'b00, a[0]};
      end
      OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        nf = {r8 == 8'h00, 3'b000};
      end
      // Accumulator rotates always clear Z.
      OP_RLCA: begin
        r8 = {a[6:0], a[7]};
        nf = {3'b000, a[7]};
      end
      OP_RRCA: begin
        r8 = {a[0], a[7:1]};
        nf = {3'b000, a[0]};
      end
      OP_RLA: begin
        r8 = {a[6:0], cf};
        nf = {3'b000, a[7]};
      end
      OP_RRA: begin
        r8 = {cf, a[7:1]};
        nf = {3'b000, a[0]};
      end
      OP_BIT: begin
        wr = 1'b0;
        nf = {(a & bit_mask) == 8'h00, 1'b0, 1'b1, cf};
      end
      OP_RES: begin
        r8 = a & ~bit_mask;
      end
      OP_SET: begin
        r8 = a | bit_mask;
      end
      OP_DAA: begin
        // Decimal adjust after add or subtract, chosen by N.
        if (f[FLAG_N]) begin
          if (f[FLAG_H]) adj = adj + 8'h06;
          if (cf) adj = adj + 8'h60;
          r8 = a - adj;
        end else begin
          if (f[FLAG_H] || a[3:0] > 4'h9) adj = adj + 8'h06;
          if (cf || a > 8'h99) begin
            adj = adj + 8'h60;
            cy  = 1'b1;
          end
          r8 = a + adj;
        end
        nf = {r8 == 8'h00, f[FLAG_N], 1'b0, cy};
      end
      OP_CCF: begin
        wr = 1'b0;
        nf = {f[FLAG_Z], 2'b00, ~cf};
      end
      OP_SCF: begin
        wr = 1'b0;
        nf = {f[FLAG_Z], 2'b00, 1'b1};
      end
      OP_ADDHL: begin
        wide = 1'b1;
        r16  = hl17[15:0];
        nf   = {f[FLAG_Z], 1'b0, hl13[12], hl17[16]};
      end
      OP_ADDSP: begin
        wide = 1'b1;
        r16  = item.operand_x + e16;
        nf   = {2'b00, sp_nib[4], sp_low9[8]};
      end
      OP_INC16: begin
        wide = 1'b1;
        r16  = item.operand_x + 16'h0001;
      end
      OP_DEC16: begin
        wide = 1'b1;
        r16  = item.operand_x - 16'h0001;
      end
      default: begin
        // Unused codes: no result, flags unchanged.
        wr = 1'b0;
      end
    endcase

    res.result        = wide ? r16 : {8'h00, r8};
    res.flags_out     = nf;
    res.writes_result = wr;
  end

endmodule

// ===== rtl/cpu8_alu_with_flags.sv =====
// Top level of the 8-bit ALU with flags: input register, datapath, result register.
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+----------------------
//   in      | into ALU  | cpu8a_pkg::in_t  | in_valid / in_stall
//   out     | from ALU  | cpu8a_pkg::out_t | out_valid / out_stall
//
// Each beat passes from acceptance into the input register and then
// through the datapath into the result register.
// One beat is accepted every cycle while the output side does not stall.
// Reset clears both valid bits; no payload register is reset.
// A stall on the output holds the result register, and in_stall rises only
// when the input register is also full.
`include "cpu8_alu_with_flags_assert.svh"

module cpu8_alu_with_flags (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cpu8a_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output cpu8a_pkg::out_t out_data
);
  import cpu8a_pkg::*;

  logic  s1_valid;
  in_t   s1_data;
  out_t  alu_res;
  logic  advance;

  // The result register moves whenever it is empty or its beat is taken.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = s1_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  cpu8a_alu u_alu (
    .item (s1_data),
    .res  (alu_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_data <= alu_res;
    end
  end

  // Input is held back only while both registers are full and blocked.
  `CPU8_ASSERT_SAME(a_stall_only_when_full, in_stall, s1_valid && out_valid && out_stall,
    "input stalled while a register had room")
  // A full input register that can move produces a result beat next cycle.
  `CPU8_ASSERT_NEXT(a_stage_moves, s1_valid && advance, out_valid,
    "beat lost between input and result register")
  // With nothing behind it, a taken result beat leaves the output empty.
  `CPU8_ASSERT_NEXT(a_no_repeat, out_valid && !out_stall && !s1_valid, !out_valid,
    "result beat repeated")
  // Non-writing operations always report a zero result.
  `CPU8_ASSERT_SAME(a_nowrite_zero, out_valid && !out_data.writes_result,
    out_data.result == 16'h0000, "nonzero result on a non-writing operation")

endmodule
